// ----- rtl/jrf_pkg.sv -----
// package: tables, widths and pipeline types for the jacobi rotation factor block
`timescale 1ns / 1ps
package jrf_pkg;

  localparam int ElemW    = 16;
  localparam int MagW     = ElemW + 1;
  localparam int QuoW     = 16;
  localparam int AngW     = 15;
  localparam int OutW     = 16;
  localparam int DivSteps = QuoW;
  localparam logic [AngW-1:0] HalfPi = 15'd12868;
  localparam logic [OutW-1:0] OneQ14 = 16'd16384;

  typedef struct packed {
    logic [MagW-1:0] rem;
    logic [MagW-1:0] hi;
    logic [QuoW-1:0] q;
    logic            swp;
    logic            neg;
    logic            zro;
  } jrf_div_t;

  typedef struct packed {
    logic [2:0]  seg;
    logic [26:0] prod;
    logic        swp;
    logic        neg;
    logic        zro;
  } jrf_atn_t;

  typedef struct packed {
    logic [2:0]  seg;
    logic [13:0] frac;
    logic        neg;
  } jrf_seg_t;

  typedef struct packed {
    logic [2:0]  seg;
    logic [24:0] ps;
    logic [24:0] pc;
    logic        neg;
  } jrf_mul_t;

  function automatic logic [12:0] atan_val(input logic [2:0] i);
    case (i)
      3'd0: atan_val = 13'd0;
      3'd1: atan_val = 13'd1019;
      3'd2: atan_val = 13'd2007;
      3'd3: atan_val = 13'd2939;
      3'd4: atan_val = 13'd3798;
      3'd5: atan_val = 13'd4576;
      3'd6: atan_val = 13'd5272;
      default: atan_val = 13'd5889;
    endcase
  endfunction

  function automatic logic [13:0] atan_slope(input logic [2:0] i);
    case (i)
      3'd0: atan_slope = 14'd16299;
      3'd1: atan_slope = 14'd15810;
      3'd2: atan_slope = 14'd14915;
      3'd3: atan_slope = 14'd13746;
      3'd4: atan_slope = 14'd12445;
      3'd5: atan_slope = 14'd11128;
      3'd6: atan_slope = 14'd9874;
      default: atan_slope = 14'd8725;
    endcase
  endfunction

  function automatic logic [13:0] trig_bp(input logic [2:0] i);
    case (i)
      3'd0: trig_bp = 14'd0;
      3'd1: trig_bp = 14'd1608;
      3'd2: trig_bp = 14'd3217;
      3'd3: trig_bp = 14'd4825;
      3'd4: trig_bp = 14'd6434;
      3'd5: trig_bp = 14'd8042;
      3'd6: trig_bp = 14'd9651;
      default: trig_bp = 14'd11259;
    endcase
  endfunction

  function automatic logic [14:0] sin_val(input logic [3:0] i);
    case (i)
      4'd0: sin_val = 15'd0;
      4'd1: sin_val = 15'd3196;
      4'd2: sin_val = 15'd6270;
      4'd3: sin_val = 15'd9102;
      4'd4: sin_val = 15'd11585;
      4'd5: sin_val = 15'd13623;
      4'd6: sin_val = 15'd15137;
      4'd7: sin_val = 15'd16069;
      default: sin_val = 15'd16384;
    endcase
  endfunction

  function automatic logic [13:0] sin_slope(input logic [2:0] i);
    case (i)
      3'd0: sin_slope = 14'd16279;
      3'd1: sin_slope = 14'd15653;
      3'd2: sin_slope = 14'd14426;
      3'd3: sin_slope = 14'd12645;
      3'd4: sin_slope = 14'd10376;
      3'd5: sin_slope = 14'd7710;
      3'd6: sin_slope = 14'd4749;
      default: sin_slope = 14'd1603;
    endcase
  endfunction

endpackage

// ----- rtl/jacobi_2x2_rotation_factors_top.sv -----
// top level: pipelined 2x2 jacobi rotation cosine and sine generator
`timescale 1ns / 1ps
// Takes one 2x2 block per transaction and returns the piecewise-linear cosine
// and sine (signed Q1.14) of the left and right rotation angles. The pipeline
// accepts one block every cycle while no result is stalled at the output. Its
// depth is set by the two ratio dividers, which resolve one quotient bit per
// stage over 16 stages, plus an input register and six stages of arctan, angle
// combine and trig lookup. The whole pipeline holds while a result waits.
module jacobi_2x2_rotation_factors_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // elem_a, elem_b, elem_c, elem_d
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // cos_left, sin_left, cos_right, sin_right
);
  import jrf_pkg::*;

  localparam int NStg = DivSteps + 7;

  logic            en;
  logic [NStg-1:0] vld_r, vld_nxt;

  jrf_div_t div0_nxt [2];
  jrf_div_t div_r [0:DivSteps][2];
  jrf_div_t div_nxt [0:DivSteps][2];
  jrf_atn_t atn_r [2], atn_nxt [2];
  logic signed [AngW-1:0] th_r [2], th_nxt [2];
  logic signed [AngW-1:0] lr_r [2], lr_nxt [2];
  jrf_seg_t seg_r [2], seg_nxt [2];
  jrf_mul_t mul_r [2], mul_nxt [2];
  logic [63:0] out_r, out_nxt;

  assign en         = !vld_r[NStg-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[NStg-1];
  assign out_tdata  = out_r;
  assign vld_nxt    = {vld_r[NStg-2:0], in_tvalid};

  // sums and differences, magnitudes and ordering
  always_comb begin
    logic signed [ElemW-1:0] a, b, c, d;
    logic signed [MagW-1:0]  num [2];
    logic signed [MagW-1:0]  den [2];
    logic [MagW-1:0]         an, ad;
    a = in_tdata[15:0];
    b = in_tdata[31:16];
    c = in_tdata[47:32];
    d = in_tdata[63:48];
    num[0] = MagW'(c) + MagW'(b);
    den[0] = MagW'(d) - MagW'(a);
    num[1] = MagW'(c) - MagW'(b);
    den[1] = MagW'(d) + MagW'(a);
    for (int p = 0; p < 2; p++) begin
      an = num[p][MagW-1] ? MagW'(-num[p]) : MagW'(num[p]);
      ad = den[p][MagW-1] ? MagW'(-den[p]) : MagW'(den[p]);
      div0_nxt[p].swp = an > ad;
      div0_nxt[p].rem = (an > ad) ? ad : an;
      div0_nxt[p].hi  = (an > ad) ? an : ad;
      div0_nxt[p].q   = '0;
      div0_nxt[p].neg = num[p][MagW-1] ^ den[p][MagW-1];
      div0_nxt[p].zro = (an <= ad) && (ad == '0);
    end
  end

  // restoring divider, one quotient bit per stage
  always_comb begin
    logic [MagW:0] t;
    div_nxt[0] = div0_nxt;
    for (int k = 0; k < DivSteps; k++) begin
      for (int p = 0; p < 2; p++) begin
        div_nxt[k+1][p] = div_r[k][p];
        t = (k == 0) ? {1'b0, div_r[k][p].rem} : {div_r[k][p].rem, 1'b0};
        if (t >= {1'b0, div_r[k][p].hi}) begin
          div_nxt[k+1][p].rem = MagW'(t - {1'b0, div_r[k][p].hi});
          div_nxt[k+1][p].q   = {div_r[k][p].q[QuoW-2:0], 1'b1};
        end else begin
          div_nxt[k+1][p].rem = t[MagW-1:0];
          div_nxt[k+1][p].q   = {div_r[k][p].q[QuoW-2:0], 1'b0};
        end
      end
    end
  end

  // arctan segment and slope product
  always_comb begin
    logic [QuoW-1:0] r;
    logic [2:0]      i;
    logic [12:0]     frac;
    for (int p = 0; p < 2; p++) begin
      r    = div_r[DivSteps][p].q;
      i    = r[15] ? 3'd7 : r[14:12];
      frac = r[15] ? 13'd4096 : {1'b0, r[11:0]};
      atn_nxt[p].seg  = i;
      atn_nxt[p].prod = 27'(atan_slope(i) * frac);
      atn_nxt[p].swp  = div_r[DivSteps][p].swp;
      atn_nxt[p].neg  = div_r[DivSteps][p].neg;
      atn_nxt[p].zro  = div_r[DivSteps][p].zro;
    end
  end

  // full-range pair angle
  always_comb begin
    logic [26:0]     rnd;
    logic [AngW-1:0] mag, ang;
    for (int p = 0; p < 2; p++) begin
      rnd = atn_r[p].prod + 27'd32768;
      mag = AngW'(atan_val(atn_r[p].seg)) + AngW'(rnd[26:16]);
      if (atn_r[p].zro) ang = HalfPi;
      else if (atn_r[p].swp) ang = HalfPi - mag;
      else ang = mag;
      th_nxt[p] = (atn_r[p].neg && !atn_r[p].zro) ? -$signed(ang) : $signed(ang);
    end
  end

  // left is half difference, right is half sum
  always_comb begin
    logic signed [AngW:0] dl, sm;
    dl = {th_r[0][AngW-1], th_r[0]} - {th_r[1][AngW-1], th_r[1]};
    sm = {th_r[0][AngW-1], th_r[0]} + {th_r[1][AngW-1], th_r[1]};
    lr_nxt[0] = dl[AngW:1];
    lr_nxt[1] = sm[AngW:1];
  end

  // trig segment search
  always_comb begin
    logic [AngW-1:0] at;
    logic [2:0]      i;
    for (int p = 0; p < 2; p++) begin
      at = lr_r[p][AngW-1] ? AngW'(-lr_r[p]) : AngW'(lr_r[p]);
      if (at > HalfPi) at = HalfPi;
      i = 3'd0;
      for (int k = 1; k < 8; k++) begin
        if (at >= {1'b0, trig_bp(3'(k))}) i = 3'(k);
      end
      seg_nxt[p].seg  = i;
      seg_nxt[p].frac = 14'(at - {1'b0, trig_bp(i)});
      seg_nxt[p].neg  = lr_r[p][AngW-1];
    end
  end

  // trig slope products
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      mul_nxt[p].seg = seg_r[p].seg;
      mul_nxt[p].neg = seg_r[p].neg;
      mul_nxt[p].ps  = 25'(sin_slope(seg_r[p].seg) * seg_r[p].frac);
      mul_nxt[p].pc  = 25'(sin_slope(~seg_r[p].seg) * seg_r[p].frac);
    end
  end

  // round, saturate and sign
  always_comb begin
    logic [24:0]          rs, rc;
    logic signed [18:0]   sv, cv;
    logic [OutW-1:0]      su, cu;
    out_nxt = '0;
    for (int p = 0; p < 2; p++) begin
      rs = mul_r[p].ps + 25'd4096;
      rc = mul_r[p].pc + 25'd4096;
      sv = $signed({4'b0, sin_val({1'b0, mul_r[p].seg})}) + $signed({7'b0, rs[24:13]});
      cv = $signed({4'b0, sin_val(4'd8 - {1'b0, mul_r[p].seg})}) -
           $signed({7'b0, rc[24:13]});
      if (sv < 0) su = '0;
      else if (sv > $signed({3'b0, OneQ14})) su = OneQ14;
      else su = sv[OutW-1:0];
      if (cv < 0) cu = '0;
      else if (cv > $signed({3'b0, OneQ14})) cu = OneQ14;
      else cu = cv[OutW-1:0];
      out_nxt[32*p +: 16]      = cu;
      out_nxt[32*p + 16 +: 16] = mul_r[p].neg ? OutW'(-su) : su;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r <= div_nxt;
      atn_r <= atn_nxt;
      th_r  <= th_nxt;
      lr_r  <= lr_nxt;
      seg_r <= seg_nxt;
      mul_r <= mul_nxt;
      out_r <= out_nxt;
    end
  end

endmodule

// ----- rtl/jrf_checker.sv -----
// checker: port-level properties of the rotation factor block, with its bind
`timescale 1ns / 1ps
module jrf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result transaction changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with no pending result");

  a_cos_l: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[15] && out_tdata[15:0] <= 16'd16384)
    else $error("left cosine out of range");

  a_cos_r: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[47] && out_tdata[47:32] <= 16'd16384)
    else $error("right cosine out of range");

endmodule

bind jacobi_2x2_rotation_factors_top jrf_checker u_jrf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
